// File: hw/rtl/debounced_keypad_mapper_with_repeat_core_defines.svh
// Assertion macros used by the keypad mapper checker.
`ifndef DEBOUNCED_KEYPAD_MAPPER_WITH_REPEAT_CORE_DEFINES_SVH
`define DEBOUNCED_KEYPAD_MAPPER_WITH_REPEAT_CORE_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off while aresetn is low
`define DKM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("keypad mapper check failed");

// Next-cycle implication, sampled on aclk, off while aresetn is low
`define DKM_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("keypad mapper check failed");

`endif

// File: hw/rtl/dkm_pkg.sv
// Package: constants, types and field layout of the keypad mapper.
`default_nettype none
package dkm_pkg;

    localparam int NUM_BUTTONS   = 8;
    localparam int MAX_KEYS      = 3;
    localparam int TIME_BITS     = 32;
    localparam int KEY_BUTTONS   = 6;
    localparam int NUM_CODES     = 3;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    // Port widths
    localparam int IN_TDATA_W    = 40;
    localparam int OUT_TDATA_W   = 56;
    localparam int OUT_TUSER_W   = 2;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 64;

    // Buttons with fixed roles
    localparam logic [2:0] BTN_SET    = 3'd6;
    localparam logic [2:0] BTN_CANCEL = 3'd7;

    localparam logic [12:0] DEFAULT_DELAY  = 13'd10;
    localparam logic [9:0]  DEBOUNCE_RESET = 10'd20;

    // Event kinds
    localparam logic [1:0] KIND_BURST  = 2'd0;
    localparam logic [1:0] KIND_SET    = 2'd1;
    localparam logic [1:0] KIND_CANCEL = 2'd2;

    // Register indexes
    localparam logic [2:0] REG_MAP_LAST     = 3'd5;
    localparam logic [2:0] REG_MAPPED_COUNT = 3'd6;
    localparam logic [2:0] REG_DEBOUNCE     = 3'd7;

    // Map word layout
    localparam int MW_LEN_LO    = 48;
    localparam int MW_TOGGLE    = 50;
    localparam int MW_DELAY_LO  = 51;

    typedef logic [TIME_BITS-1:0] tick_time_t;
    typedef logic [63:0]          map_word_t;
    typedef logic [15:0]          key_code_t;

    // One result transaction
    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] btn;
        logic [1:0] cnt;
        key_code_t  code_c;
        key_code_t  code_b;
        key_code_t  code_a;
        logic       last;
    } result_t;

    // One classified tick handed from front to back
    typedef struct packed {
        logic [NUM_BUTTONS-1:0] pressed;
        tick_time_t             now;
    } tick_entry_t;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage
`default_nettype wire

// File: hw/rtl/debounced_keypad_mapper_with_repeat_core.sv
// Top level of the debounced keypad mapper with toggle auto-repeat.
//
//  channel   dir   payload (low bit first)                          end flag
//  s_ tick   in    tdata: raw_levels[7:0], now_ms[39:8]              -
//  m_ event  out   tdata: source_button, key_count, codes a, b, c;   tlast
//                  tuser: event_kind
//  cfg       in    index 0-5 map words, 6 mapped_count, 7 debounce   -
//
// The back takes each tick through its states in order: ST_IDLE picks it up
// from the queue, ST_BTN walks the buttons one per cycle while not blocked,
// ST_REP makes the repeat check and ST_DONE hands the held result, marked
// last, to the output register. Reset is synchronous and active low; no
// clearing pass. The front takes a new tick while the two-entry queue has
// room; the back stalls when a result must move on while one is held and the
// output register is still full.
`default_nettype none
module debounced_keypad_mapper_with_repeat_core (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [dkm_pkg::IN_TDATA_W-1:0]     s_tdata,   // raw_levels, now_ms
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [dkm_pkg::OUT_TDATA_W-1:0]         m_tdata,   // source_button, key_count,
                                                               // key_code_a, _b, _c
    output logic [dkm_pkg::OUT_TUSER_W-1:0]         m_tuser,   // event_kind
    output logic                                    m_tlast,   // last_of_tick
    input  wire logic                               cfg_wr_en,
    input  wire logic [dkm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [dkm_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    dkm_pkg::map_word_t   map_word_reg [dkm_pkg::KEY_BUTTONS];
    logic [2:0]           mapped_count_reg;
    logic [9:0]           settle_ms_reg;

    logic                 tick_fire;
    dkm_pkg::tick_entry_t front_entry, q_head;
    dkm_pkg::q_status_t   q_status;
    logic                 q_pop;
    dkm_pkg::result_t     result;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < dkm_pkg::KEY_BUTTONS; i++) begin
                map_word_reg[i] <= '0;
            end
            mapped_count_reg <= '0;
            settle_ms_reg    <= dkm_pkg::DEBOUNCE_RESET;
        end else if (cfg_wr_en) begin
            if (cfg_index <= dkm_pkg::REG_MAP_LAST) begin
                map_word_reg[cfg_index] <= cfg_wdata;
            end else if (cfg_index == dkm_pkg::REG_MAPPED_COUNT) begin
                mapped_count_reg <= cfg_wdata[2:0];
            end else if (cfg_index == dkm_pkg::REG_DEBOUNCE) begin
                settle_ms_reg <= cfg_wdata[9:0];
            end
        end
    end

    assign s_tready  = !q_status.full;
    assign tick_fire = s_tvalid && s_tready;

    dkm_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .tick_fire   (tick_fire),
        .raw_levels  (s_tdata[7:0]),
        .now_t       (s_tdata[8 +: dkm_pkg::TIME_BITS]),
        .settle_ms   (settle_ms_reg),
        .entry       (front_entry)
    );

    dkm_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (tick_fire),
        .push_entry (front_entry),
        .pop        (q_pop),
        .head       (q_head),
        .status     (q_status)
    );

    dkm_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_status     (q_status),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .map_words    (map_word_reg),
        .mapped_count (mapped_count_reg),
        .out_result   (result),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready)
    );

    // Output packing
    assign m_tdata = {3'b000, result.code_c, result.code_b, result.code_a,
                      result.cnt, result.btn};
    assign m_tuser = result.kind;
    assign m_tlast = result.last;

endmodule
`default_nettype wire

// File: hw/rtl/dkm_front.sv
// Front end: debounces the raw levels of each tick and finds new presses.
`default_nettype none
module dkm_front (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        tick_fire,
    input  wire logic [7:0]                  raw_levels,
    input  wire dkm_pkg::tick_time_t         now_t,
    input  wire logic [9:0]                  settle_ms,
    output dkm_pkg::tick_entry_t             entry
);

    logic [dkm_pkg::NUM_BUTTONS-1:0] stable_level_reg, stable_level_next;
    dkm_pkg::tick_time_t agree_time_reg  [dkm_pkg::NUM_BUTTONS];
    dkm_pkg::tick_time_t agree_time_next [dkm_pkg::NUM_BUTTONS];
    logic [dkm_pkg::NUM_BUTTONS-1:0] pressed;

    // Per-button debounce, all buttons side by side
    always_comb begin
        dkm_pkg::tick_time_t elapsed;
        stable_level_next = stable_level_reg;
        pressed           = '0;
        elapsed           = '0;
        for (int i = 0; i < dkm_pkg::NUM_BUTTONS; i++) begin
            agree_time_next[i] = agree_time_reg[i];
            if (raw_levels[i] != stable_level_reg[i]) begin
                elapsed = now_t - agree_time_reg[i];
                if (elapsed > dkm_pkg::tick_time_t'(settle_ms)) begin
                    agree_time_next[i]   = now_t;
                    stable_level_next[i] = raw_levels[i];
                    pressed[i]           = ~raw_levels[i];
                end
            end else begin
                agree_time_next[i] = now_t;
            end
        end
    end

    assign entry.pressed = pressed;
    assign entry.now     = now_t;

    // State update on each accepted tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stable_level_reg <= '1;
            for (int i = 0; i < dkm_pkg::NUM_BUTTONS; i++) begin
                agree_time_reg[i] <= '0;
            end
        end else if (tick_fire) begin
            stable_level_reg <= stable_level_next;
            for (int i = 0; i < dkm_pkg::NUM_BUTTONS; i++) begin
                agree_time_reg[i] <= agree_time_next[i];
            end
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/dkm_queue.sv
// Short queue of classified ticks between front and back.
`default_nettype none
module dkm_queue (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 push,
    input  wire dkm_pkg::tick_entry_t push_entry,
    input  wire logic                 pop,
    output dkm_pkg::tick_entry_t      head,
    output dkm_pkg::q_status_t        status
);

    dkm_pkg::tick_entry_t slot_reg [dkm_pkg::QUEUE_DEPTH];
    logic [dkm_pkg::QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [dkm_pkg::QCNT_W-1:0] count_reg, count_next;
    logic do_push, do_pop;

    assign status.full  = (count_reg == dkm_pkg::QCNT_W'(dkm_pkg::QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = slot_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/dkm_back.sv
// Back end: walks the presses of one tick, runs the repeat and emits results.
`default_nettype none
module dkm_back (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire dkm_pkg::q_status_t   q_status,
    input  wire dkm_pkg::tick_entry_t q_head,
    output logic                      q_pop,
    input  wire dkm_pkg::map_word_t   map_words [dkm_pkg::KEY_BUTTONS],
    input  wire logic [2:0]           mapped_count,
    output dkm_pkg::result_t          out_result,
    output logic                      out_valid,
    input  wire logic                 out_ready
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_BTN  = 2'd1;
    localparam logic [1:0] ST_REP  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [2:0] idx_reg, idx_next;

    // Repeat state
    logic                 rep_active_reg, rep_active_next;
    logic [2:0]           rep_btn_reg, rep_btn_next;
    dkm_pkg::key_code_t   rep_codes_reg [dkm_pkg::NUM_CODES];
    dkm_pkg::key_code_t   rep_codes_next [dkm_pkg::NUM_CODES];
    logic [1:0]           rep_cnt_reg, rep_cnt_next;
    logic [12:0]          rep_int_reg, rep_int_next;
    dkm_pkg::tick_time_t  rep_last_reg, rep_last_next;

    // Held result and output register
    dkm_pkg::result_t pend_reg, pend_next;
    logic             pend_valid_reg, pend_valid_next;
    dkm_pkg::result_t out_reg, out_next;
    logic             out_valid_reg, out_valid_next;

    // Per-step decode
    dkm_pkg::map_word_t  word;
    logic [1:0]          len;
    logic [2:0]          limit;
    dkm_pkg::key_code_t  codes [dkm_pkg::NUM_CODES];
    dkm_pkg::tick_time_t rep_elapsed;
    logic                cand_valid;
    dkm_pkg::result_t    cand;
    logic                out_free, blocked;

    assign out_free    = !out_valid_reg || out_ready;
    assign out_valid   = out_valid_reg;
    assign out_result  = out_reg;
    assign limit       = (mapped_count > 3'(dkm_pkg::KEY_BUTTONS)) ?
                         3'(dkm_pkg::KEY_BUTTONS) : mapped_count;
    assign rep_elapsed = q_head.now - rep_last_reg;

    // Mapping of the current button, length clamped and unused codes zeroed
    always_comb begin
        word = (idx_reg < 3'(dkm_pkg::KEY_BUTTONS)) ? map_words[idx_reg] : '0;
        len  = word[dkm_pkg::MW_LEN_LO +: 2];
        if (len > 2'(dkm_pkg::MAX_KEYS)) begin
            len = 2'(dkm_pkg::MAX_KEYS);
        end
        for (int k = 0; k < dkm_pkg::NUM_CODES; k++) begin
            codes[k] = (2'(k) < len) ? word[16*k +: 16] : '0;
        end
    end

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        rep_active_next = rep_active_reg;
        rep_btn_next    = rep_btn_reg;
        rep_cnt_next    = rep_cnt_reg;
        rep_int_next    = rep_int_reg;
        rep_last_next   = rep_last_reg;
        for (int k = 0; k < dkm_pkg::NUM_CODES; k++) begin
            rep_codes_next[k] = rep_codes_reg[k];
        end
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        q_pop           = 1'b0;
        cand_valid      = 1'b0;
        cand            = '0;
        blocked         = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (!q_status.empty) begin
                    state_next = ST_BTN;
                    idx_next   = '0;
                end
            end
            ST_BTN: begin
                if (q_head.pressed[idx_reg]) begin
                    if (idx_reg == dkm_pkg::BTN_SET) begin
                        cand_valid = 1'b1;
                        cand.kind  = dkm_pkg::KIND_SET;
                        cand.btn   = idx_reg;
                    end else if (idx_reg == dkm_pkg::BTN_CANCEL) begin
                        cand_valid = 1'b1;
                        cand.kind  = dkm_pkg::KIND_CANCEL;
                        cand.btn   = idx_reg;
                    end else if (idx_reg < limit && len != 2'd0) begin
                        if (!word[dkm_pkg::MW_TOGGLE]) begin
                            cand_valid  = 1'b1;
                        end else if (rep_active_reg && rep_btn_reg == idx_reg) begin
                            // toggle of the running button: stop silently
                            rep_active_next = 1'b0;
                            rep_cnt_next    = '0;
                            for (int k = 0; k < dkm_pkg::NUM_CODES; k++) begin
                                rep_codes_next[k] = '0;
                            end
                        end else begin
                            // start a new repeat, replacing any other
                            cand_valid      = 1'b1;
                            rep_active_next = 1'b1;
                            rep_btn_next    = idx_reg;
                            rep_cnt_next    = len;
                            for (int k = 0; k < dkm_pkg::NUM_CODES; k++) begin
                                rep_codes_next[k] = codes[k];
                            end
                            rep_int_next  = word[dkm_pkg::MW_DELAY_LO +: 13];
                            if (rep_int_next == '0) begin
                                rep_int_next = dkm_pkg::DEFAULT_DELAY;
                            end
                            rep_last_next = q_head.now;
                        end
                        cand.kind   = dkm_pkg::KIND_BURST;
                        cand.btn    = idx_reg;
                        cand.cnt    = len;
                        cand.code_a = codes[0];
                        cand.code_b = codes[1];
                        cand.code_c = codes[2];
                    end
                end
                if (idx_reg == 3'(dkm_pkg::NUM_BUTTONS - 1)) begin
                    state_next = ST_REP;
                end
                idx_next = idx_reg + 1'b1;
            end
            ST_REP: begin
                if (rep_active_reg &&
                    rep_elapsed >= dkm_pkg::tick_time_t'(rep_int_reg)) begin
                    cand_valid    = 1'b1;
                    rep_last_next = q_head.now;
                end
                cand.kind   = dkm_pkg::KIND_BURST;
                cand.btn    = rep_btn_reg;
                cand.cnt    = rep_cnt_reg;
                cand.code_a = rep_codes_reg[0];
                cand.code_b = rep_codes_reg[1];
                cand.code_c = rep_codes_reg[2];
                state_next  = ST_DONE;
            end
            ST_DONE: begin
                if (!pend_valid_reg) begin
                    q_pop      = 1'b1;
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    out_next          = pend_reg;
                    out_next.last     = 1'b1;
                    out_valid_next    = 1'b1;
                    pend_valid_next   = 1'b0;
                    q_pop             = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // A new result needs the held one moved on first
        if (cand_valid) begin
            blocked = pend_valid_reg && !out_free;
            if (!blocked) begin
                if (pend_valid_reg) begin
                    out_next       = pend_reg;
                    out_valid_next = 1'b1;
                end
                pend_next       = cand;
                pend_valid_next = 1'b1;
            end
        end

        // Hold the whole step while blocked
        if (blocked) begin
            state_next      = state_reg;
            idx_next        = idx_reg;
            rep_active_next = rep_active_reg;
            rep_btn_next    = rep_btn_reg;
            rep_cnt_next    = rep_cnt_reg;
            rep_int_next    = rep_int_reg;
            rep_last_next   = rep_last_reg;
            for (int k = 0; k < dkm_pkg::NUM_CODES; k++) begin
                rep_codes_next[k] = rep_codes_reg[k];
            end
        end
    end

    // Control and repeat state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            rep_active_reg <= 1'b0;
            rep_btn_reg    <= '0;
            rep_cnt_reg    <= '0;
            rep_int_reg    <= '0;
            rep_last_reg   <= '0;
            for (int k = 0; k < dkm_pkg::NUM_CODES; k++) begin
                rep_codes_reg[k] <= '0;
            end
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            rep_active_reg <= rep_active_next;
            rep_btn_reg    <= rep_btn_next;
            rep_cnt_reg    <= rep_cnt_next;
            rep_int_reg    <= rep_int_next;
            rep_last_reg   <= rep_last_next;
            for (int k = 0; k < dkm_pkg::NUM_CODES; k++) begin
                rep_codes_reg[k] <= rep_codes_next[k];
            end
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

endmodule
`default_nettype wire

// File: hw/rtl/dkm_checker.sv
// Port-level checks on the keypad mapper, bound to the top level.
`default_nettype none
`include "debounced_keypad_mapper_with_repeat_core_defines.svh"
module dkm_checker (
    input wire logic                               aclk,
    input wire logic                               aresetn,
    input wire logic                               m_tvalid,
    input wire logic                               m_tready,
    input wire logic [dkm_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input wire logic [dkm_pkg::OUT_TUSER_W-1:0]    m_tuser,
    input wire logic                               m_tlast
);

    logic [2:0]  m_btn;
    logic [1:0]  m_cnt;
    logic [15:0] m_code_b, m_code_c;
    logic [49:0] m_payload;
    logic        m_stall, is_set, is_cancel, is_burst;

    // Result fields as packed on the port
    assign m_btn     = m_tdata[2:0];
    assign m_cnt     = m_tdata[4:3];
    assign m_code_b  = m_tdata[36:21];
    assign m_code_c  = m_tdata[52:37];
    assign m_payload = m_tdata[52:3];
    assign m_stall   = m_tvalid && !m_tready;
    assign is_set    = m_tvalid && (m_tuser == dkm_pkg::KIND_SET);
    assign is_cancel = m_tvalid && (m_tuser == dkm_pkg::KIND_CANCEL);
    assign is_burst  = m_tvalid && (m_tuser == dkm_pkg::KIND_BURST);

    // A stalled result holds still
    `DKM_ASSERT_NXT(a_out_hold, m_stall, m_tvalid && $stable({m_tdata, m_tuser, m_tlast}))

    // Profile set comes from button 6, cancel from button 7, both without codes
    `DKM_ASSERT_IMP(a_profile_set, is_set, m_btn == dkm_pkg::BTN_SET && m_payload == '0)
    `DKM_ASSERT_IMP(a_profile_cancel, is_cancel, m_btn == dkm_pkg::BTN_CANCEL && m_payload == '0)

    // A burst carries at least one code from a key button, unused slots are zero
    `DKM_ASSERT_IMP(a_burst_count, is_burst, m_cnt != 2'd0 && m_btn < 3'(dkm_pkg::KEY_BUTTONS))
    `DKM_ASSERT_IMP(a_burst_zero, is_burst, (m_cnt == 2'd3 || m_code_c == '0) && (m_cnt != 2'd1 || m_code_b == '0))

endmodule

bind debounced_keypad_mapper_with_repeat_core dkm_checker u_dkm_checker (.*);
`default_nettype wire

// File: dv/debounced_keypad_mapper_with_repeat_core_test.sv
// Self-checking testbench for the debounced keypad mapper with toggle auto-repeat.
`timescale 1ns / 100ps

module debounced_keypad_mapper_with_repeat_core_test;
    import dkm_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 500000;
    localparam int unsigned SETTLE_CYCLES = 40;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned RAND_PHASES   = 8;
    localparam int unsigned TICKS_PER_PH  = 60;

    // Receiver stall modes
    localparam int unsigned RX_ALWAYS  = 0;
    localparam int unsigned RX_RANDOM  = 1;
    localparam int unsigned RX_PATTERN = 2;

    logic                      aclk;
    logic                      aresetn;
    logic                      s_tvalid;
    logic                      s_tready;
    logic [IN_TDATA_W-1:0]     s_tdata;
    logic                      m_tvalid;
    logic                      m_tready;
    logic [OUT_TDATA_W-1:0]    m_tdata;
    logic [OUT_TUSER_W-1:0]    m_tuser;
    logic                      m_tlast;
    logic                      cfg_wr_en;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [CFG_DATA_W-1:0]     cfg_wdata;

    logic                      hold_req = 1'b0;
    int unsigned               burst_left = 0;
    int unsigned               cycles = 0;

    debounced_keypad_mapper_with_repeat_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Keypad predictor and store of expected events
    class keypad_scoreboard;
        map_word_t   map_words [KEY_BUTTONS];
        logic [2:0]  mapped_cnt;
        logic [9:0]  settle_ms;
        logic [7:0]  stable_lvl;
        tick_time_t  agree_at [NUM_BUTTONS];
        logic        rep_on;
        logic [2:0]  rep_btn;
        logic [47:0] rep_codes;
        logic [1:0]  rep_cnt;
        logic [12:0] rep_period;
        tick_time_t  rep_since;
        result_t     pending_events [$];
        int unsigned errors;

        function new();
            foreach (map_words[i]) map_words[i] = '0;
            foreach (agree_at[i]) agree_at[i] = '0;
            mapped_cnt  = '0;
            settle_ms   = DEBOUNCE_RESET;
            stable_lvl  = 8'hFF;
            rep_on      = 1'b0;
            rep_btn     = '0;
            rep_codes   = '0;
            rep_cnt     = '0;
            rep_period  = '0;
            rep_since   = '0;
            errors      = 0;
        endfunction

        function void set_reg(logic [2:0] idx, map_word_t val);
            if (idx <= REG_MAP_LAST)
                map_words[idx] = val;
            else if (idx == REG_MAPPED_COUNT)
                mapped_cnt = val[2:0];
            else if (idx == REG_DEBOUNCE)
                settle_ms = val[9:0];
        endfunction

        // Codes at or beyond the count read as zero
        function logic [47:0] mask_codes(logic [47:0] codes, logic [1:0] cnt);
            logic [47:0] m;
            m = codes;
            if (cnt < 2'd3) m[47:32] = '0;
            if (cnt < 2'd2) m[31:16] = '0;
            if (cnt < 2'd1) m[15:0]  = '0;
            return m;
        endfunction

        function result_t make_event(logic [1:0] kind, logic [2:0] btn, logic [1:0] cnt,
                                     logic [47:0] codes);
            result_t e;
            e.kind = kind;
            e.btn  = btn;
            e.cnt  = cnt;
            {e.code_c, e.code_b, e.code_a} = mask_codes(codes, cnt);
            e.last = 1'b0;
            return e;
        endfunction

        // One accepted poll tick: debounce, handle presses, then the repeat
        function void note_tick(logic [7:0] raw, tick_time_t now);
            logic [7:0]  pressed;
            int unsigned lim;
            map_word_t   w;
            logic [1:0]  len;
            result_t     tick_events [$];
            pressed = '0;
            lim = (mapped_cnt > KEY_BUTTONS) ? KEY_BUTTONS : mapped_cnt;

            for (int i = 0; i < NUM_BUTTONS; i++) begin
                if (raw[i] != stable_lvl[i]) begin
                    if ((now - agree_at[i]) > tick_time_t'(settle_ms)) begin
                        agree_at[i]   = now;
                        stable_lvl[i] = raw[i];
                        if (!raw[i]) pressed[i] = 1'b1;
                    end
                end else begin
                    agree_at[i] = now;
                end
            end

            for (int i = 0; i < NUM_BUTTONS; i++) begin
                if (!pressed[i]) continue;
                if (i == BTN_SET) begin
                    tick_events.push_back(make_event(KIND_SET, 3'(i), 2'd0, '0));
                    continue;
                end
                if (i == BTN_CANCEL) begin
                    tick_events.push_back(make_event(KIND_CANCEL, 3'(i), 2'd0, '0));
                    continue;
                end
                if (i >= lim) continue;
                w   = map_words[i];
                len = w[MW_LEN_LO +: 2];
                if (len == 2'd0) continue;
                if (!w[MW_TOGGLE]) begin
                    tick_events.push_back(make_event(KIND_BURST, 3'(i), len, w[47:0]));
                    continue;
                end
                // toggle pressed again stops the repeat silently
                if (rep_on && rep_btn == 3'(i)) begin
                    rep_on    = 1'b0;
                    rep_cnt   = '0;
                    rep_codes = '0;
                    continue;
                end
                rep_on     = 1'b1;
                rep_btn    = 3'(i);
                rep_cnt    = len;
                rep_codes  = mask_codes(w[47:0], len);
                rep_period = w[MW_DELAY_LO +: 13];
                if (rep_period == '0) rep_period = DEFAULT_DELAY;
                rep_since  = now;
                tick_events.push_back(make_event(KIND_BURST, rep_btn, rep_cnt, rep_codes));
            end

            if (rep_on && (now - rep_since) >= tick_time_t'(rep_period)) begin
                rep_since = now;
                tick_events.push_back(make_event(KIND_BURST, rep_btn, rep_cnt, rep_codes));
            end

            if (tick_events.size() > 0) tick_events[tick_events.size()-1].last = 1'b1;
            foreach (tick_events[k]) pending_events.push_back(tick_events[k]);
        endfunction

        function void compare_field(string field, longint unsigned want, longint unsigned got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending_events.size() == 0) begin
                $display("%0t: unexpected event, expected none, actual %0h", $time, got);
                errors++;
                return;
            end
            want = pending_events.pop_front();
            compare_field("event_kind",    want.kind,   got.kind);
            compare_field("source_button", want.btn,    got.btn);
            compare_field("key_count",     want.cnt,    got.cnt);
            compare_field("key_code_a",    want.code_a, got.code_a);
            compare_field("key_code_b",    want.code_b, got.code_b);
            compare_field("key_code_c",    want.code_c, got.code_c);
            compare_field("last_of_tick",  want.last,   got.last);
        endfunction

        function int unsigned outstanding();
            return pending_events.size();
        endfunction
    endclass

    keypad_scoreboard sb;

    // Clock
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Accepted tick transactions feed the predictor
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            sb.note_tick(s_tdata[7:0], s_tdata[39:8]);
    end

    // Accepted event transactions are checked
    always @(posedge aclk) begin : event_monitor
        result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.kind   = m_tuser;
            got.btn    = m_tdata[2:0];
            got.cnt    = m_tdata[4:3];
            got.code_a = m_tdata[20:5];
            got.code_b = m_tdata[36:21];
            got.code_c = m_tdata[52:37];
            got.last   = m_tlast;
            sb.check_result(got);
        end
    end

    // Receiver: changing stall modes, plus one long hold-off on request
    initial begin : receiver
        int unsigned mode, mode_left, beat;
        mode = RX_ALWAYS;
        mode_left = 0;
        beat = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(RX_ALWAYS, RX_PATTERN);
                mode_left = $urandom_range(30, 300);
            end
            mode_left--;
            beat++;
            case (mode)
                RX_ALWAYS: m_tready = 1'b1;
                RX_RANDOM: m_tready = 1'($urandom_range(0, 1));
                default:   m_tready = (beat % 7) < 3;
            endcase
        end
    end

    // Watchdog
    initial begin : watchdog
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("debounced_keypad_mapper_with_repeat_core test failed");
        $finish;
    end

    // Offer one tick; the sender runs in bursts with random gaps
    task automatic send_tick(logic [7:0] raw, tick_time_t now);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid = 1'b0;
                s_tdata  = {8'($urandom), $urandom};
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = {now, raw};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stop sending and wait for every expected event, then let the block settle
    task automatic drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (sb.outstanding() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        burst_left = 0;
    endtask

    task automatic write_reg(logic [2:0] idx, map_word_t val);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(posedge aclk);
        sb.set_reg(idx, val);
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    function automatic map_word_t mk_map(key_code_t a, key_code_t b, key_code_t c,
                                         logic [1:0] len, logic tog, logic [12:0] dly);
        return {dly, tog, len, c, b, a};
    endfunction

    // Mostly short delays so repeats fire often, sometimes zero or anything
    function automatic map_word_t rand_map();
        int unsigned sel;
        logic [12:0] dly;
        sel = $urandom_range(0, 9);
        if (sel < 5)      dly = 13'($urandom_range(0, 30));
        else if (sel < 7) dly = 13'd0;
        else              dly = 13'($urandom);
        return mk_map(16'($urandom), 16'($urandom), 16'($urandom),
                      2'($urandom), 1'($urandom), dly);
    endfunction

    initial begin : stimulus
        logic [7:0]  held, raw;
        tick_time_t  t, now;
        int unsigned deb, step, r;
        logic [2:0]  mc;

        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        sb = new();
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Reset settings: nothing mapped, 20 ms debounce, profile buttons only
        send_tick(8'hFF, 1000);
        send_tick(8'h3F, 1010);      // too soon
        send_tick(8'h3F, 1021);      // set and cancel
        send_tick(8'hFF, 1030);
        send_tick(8'hFF, 1042);      // release accepted, silent
        send_tick(8'h3F, 1062);      // exactly the debounce time, not enough
        send_tick(8'h3F, 1063);
        send_tick(8'hFF, 1100);
        drain();

        // Every kind of mapping, mapped count above six, no debounce
        write_reg(3'd0, mk_map(16'hFFFF, 16'h0000, 16'hA5A5, 2'd3, 1'b0, 13'h1FFF));
        write_reg(3'd1, mk_map(16'h1234, 16'hBEEF, 16'hCAFE, 2'd1, 1'b0, 13'd0));
        write_reg(3'd2, mk_map(16'h0001, 16'h8000, 16'h7777, 2'd2, 1'b1, 13'd0));
        write_reg(3'd3, mk_map(16'h5A5A, 16'hC3C3, 16'h0F0F, 2'd3, 1'b1, 13'h1FFF));
        write_reg(3'd4, mk_map(16'hDEAD, 16'hFFFF, 16'hFFFF, 2'd0, 1'b1, 13'd5));
        write_reg(REG_MAP_LAST, mk_map(16'h00FF, 16'hFF00, 16'h1111, 2'd2, 1'b0, 13'd3));
        write_reg(REG_MAPPED_COUNT, 64'd7);
        write_reg(REG_DEBOUNCE, 64'd0);
        send_tick(8'hFF, 2000);
        send_tick(8'h00, 2001);      // everything at once, second toggle replaces first
        send_tick(8'hFF, 2002);
        send_tick(8'hF7, 2003);      // active toggle pressed again: stop
        send_tick(8'hFF, 2004);
        send_tick(8'hFB, 2005);      // toggle with default interval
        send_tick(8'hFF, 2006);
        send_tick(8'hFF, 2014);      // one short of the interval
        send_tick(8'hFF, 2015);      // repeat due
        drain();

        // Remap buttons 2..4 as short while button 2 still repeats: nine events on the all-pressed tick
        write_reg(3'd2, mk_map(16'h2222, 16'h3333, 16'h4444, 2'd3, 1'b0, 13'd0));
        write_reg(3'd3, mk_map(16'h6666, 16'h9999, 16'hAAAA, 2'd3, 1'b0, 13'd0));
        write_reg(3'd4, mk_map(16'hFFFF, 16'h0000, 16'h0000, 2'd1, 1'b0, 13'd0));
        send_tick(8'h00, 2030);
        send_tick(8'hFF, 2031);
        send_tick(8'hFF, 32'hFFFF_FFFE);
        send_tick(8'hFF, 32'h0000_0003);   // across the wrap, not yet due
        send_tick(8'hFF, 32'h0000_0008);
        drain();

        // Random phases, each with fresh settings
        held = 8'hFF;
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            if (ph == 1)      mc = 3'd7;
            else if (ph == 3) mc = 3'd0;
            else if (ph == 2) mc = 3'd6;
            else              mc = 3'($urandom_range(0, 7));
            if (ph == 0)      deb = 0;
            else if (ph == 4) deb = 1023;
            else if (ph == 6) deb = $urandom_range(0, 1023);
            else              deb = $urandom_range(0, 40);
            for (int i = 0; i < KEY_BUTTONS; i++) write_reg(3'(i), rand_map());
            write_reg(REG_MAPPED_COUNT, 64'(mc));
            write_reg(REG_DEBOUNCE, 64'(deb));
            t = (ph == 5) ? 32'hFFFF_FF00 : $urandom;
            if (ph == 2) hold_req = 1'b1;

            for (int n = 0; n < TICKS_PER_PH; n++) begin
                r = $urandom_range(0, 99);
                if (r < 3) begin
                    // noise: arbitrary levels and time
                    raw = 8'($urandom);
                    now = $urandom;
                end else begin
                    if (r < 30)      held ^= 8'(1 << $urandom_range(0, 7));
                    else if (r < 36) held ^= 8'($urandom);
                    raw = held;
                    if ($urandom_range(0, 9) == 0) raw ^= 8'(1 << $urandom_range(0, 7));
                    step = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 20000)
                                                        : $urandom_range(0, deb / 3 + 4);
                    t += step;
                    now = t;
                end
                send_tick(raw, now);
            end
            drain();
        end

        if (sb.errors == 0)
            $display("debounced_keypad_mapper_with_repeat_core test passed");
        else
            $display("debounced_keypad_mapper_with_repeat_core test failed");
        $finish;
    end

endmodule

// File: debounced_keypad_mapper_with_repeat_core.f
+incdir+hw/rtl
hw/rtl/dkm_pkg.sv
hw/rtl/dkm_front.sv
hw/rtl/dkm_queue.sv
hw/rtl/dkm_back.sv
hw/rtl/debounced_keypad_mapper_with_repeat_core.sv
hw/rtl/dkm_checker.sv
dv/debounced_keypad_mapper_with_repeat_core_test.sv
